// ===== rtl/unpi_pkg.sv =====
package unpi_pkg;

   localparam int unsigned TwN = 624;
   localparam int unsigned TwM = 397;
   localparam int unsigned IdxW = 10;
   localparam logic [31:0] SeedMul = 32'd1812433253;
   localparam logic [31:0] MatrixA = 32'h9908b0df;
   localparam logic [15:0] AmountReset = 16'd6528;

   localparam logic [1:0] CSR_AMOUNT = 2'd0;
   localparam logic [1:0] CSR_COLOR  = 2'd1;
   localparam logic [1:0] CSR_SEED   = 2'd2;

   typedef logic [IdxW-1:0] idx_type;

   // controller to datapath
   typedef struct packed {
      logic seed_start;   // write word 0 from seed, reset seeding chain
      logic seed_step;    // write next seeded word
      logic load_pixel;   // capture pixel
      logic refill_rd;    // issue reads for refill of entry idx
      logic refill_wr;    // write refilled entry
      logic draw_rd;      // issue read of draw word
      logic draw_use;     // word available: apply to channel
      logic [1:0] chan;   // 0..2 channel, 3 = discard
      logic mono;         // apply to all channels
      logic out_load;     // result into output register
      idx_type idx;
   } unpi_cmd_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== rtl/unpi_pixel_if.sv =====
interface unpi_pixel_if;
   logic valid;
   logic ready;
   logic frame_start;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, frame_start, red, green, blue, input ready);
   modport sink (input valid, frame_start, red, green, blue, output ready);
endinterface

// ===== rtl/unpi_datapath.sv =====
module unpi_datapath (
   input  logic clock,
   input  unpi_pkg::unpi_cmd_type cmd,
   input  logic [15:0] amount,
   input  logic [31:0] seed,
   input  logic [7:0] red_in,
   input  logic [7:0] green_in,
   input  logic [7:0] blue_in,
   output logic [7:0] red_out,
   output logic [7:0] green_out,
   output logic [7:0] blue_out
);
   import unpi_pkg::*;

   logic [31:0] mem_a [TwN];   // copy used for word i
   logic [31:0] mem_b [TwN];   // copy used for word i+1
   logic [31:0] mem_c [TwN];   // copy used for word i+M
   logic [31:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] mul_ff;
   logic [7:0]  pix_ff [3];
   logic [7:0]  res_ff [3];
   logic [7:0]  out_ff [3];
   logic        wr_en;
   logic [31:0] wr_data;
   idx_type     wr_addr, rd_addr_b, rd_addr_c;
   logic [31:0] y, v;
   logic [31:0] tw;
   logic signed [24:0] m;
   logic signed [41:0] prod_ff;

   // seeding: prev^(prev>>30) times constant, plus index; product registered in mul_ff
   assign prev_in = prev_ff ^ (prev_ff >> 30);

   assign rd_addr_b = (cmd.idx == idx_type'(TwN-1)) ? '0 : cmd.idx + idx_type'(1);
   assign rd_addr_c = (cmd.idx >= idx_type'(TwN-TwM)) ?
                      cmd.idx - idx_type'(TwN-TwM) : cmd.idx + idx_type'(TwM);

   assign y = {rd_a_ff[31], rd_b_ff[30:0]};
   assign v = rd_c_ff ^ (y >> 1) ^ (y[0] ? MatrixA : 32'd0);

   always_comb begin
      wr_en = 1'b0;
      wr_data = v;
      wr_addr = cmd.idx;
      if (cmd.seed_start) begin
         wr_en = 1'b1;
         wr_data = seed;
      end else if (cmd.seed_step) begin
         wr_en = 1'b1;
         wr_data = mul_ff + 32'(cmd.idx);
      end else if (cmd.refill_wr) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_data;
         mem_b[wr_addr] <= wr_data;
         mem_c[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[cmd.idx];
      rd_b_ff <= mem_b[rd_addr_b];
      rd_c_ff <= mem_c[rd_addr_c];
      if (cmd.seed_start || cmd.seed_step) prev_ff <= wr_data;
      mul_ff <= SeedMul * prev_in;
   end

   // noise product: (tw[31:8] - 2^23) * amount, registered
   assign tw = temper(rd_a_ff);
   assign m = $signed({1'b0, tw[31:8]}) - 25'sd8388608;

   always_ff @(posedge clock) begin
      prod_ff <= m * $signed({1'b0, amount});
   end

   function automatic logic [7:0] apply(input logic [7:0] p,
                                        input logic signed [41:0] n);
      logic signed [43:0] s;
      s = $signed({5'd0, p, 31'd0}) + 44'(n);
      if (s <= 0) return 8'd0;
      if (s[43:31] > 13'd255) return 8'd255;
      return s[38:31];
   endfunction

   // draw_use refers to product of word read earlier, through rd_a_ff and prod_ff (timing set by controller)
   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pix_ff[0] <= red_in;
         pix_ff[1] <= green_in;
         pix_ff[2] <= blue_in;
      end
      if (cmd.draw_use) begin
         if (cmd.mono) begin
            res_ff[0] <= apply(pix_ff[0], prod_ff);
            res_ff[1] <= apply(pix_ff[1], prod_ff);
            res_ff[2] <= apply(pix_ff[2], prod_ff);
         end else if (cmd.chan != 2'd3) begin
            res_ff[cmd.chan] <= apply(pix_ff[cmd.chan], prod_ff);
         end
      end
      if (cmd.out_load) out_ff <= res_ff;
   end

   assign red_out = out_ff[0];
   assign green_out = out_ff[1];
   assign blue_out = out_ff[2];

endmodule

// ===== rtl/unpi_controller.sv =====
module unpi_controller (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic in_frame_start,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   input  logic color_mode,
   output unpi_pkg::unpi_cmd_type cmd
);
   import unpi_pkg::*;

   typedef enum logic [2:0] {
      IDLE, SEED, REFILL, DRAW, FINISH
   } state_type;

   state_type state_ff;
   idx_type   cnt_ff;      // seed/refill index
   idx_type   tw_idx_ff;   // generator draw index; empty is shown by has_idx_ff
   logic      has_idx_ff;  // tw_idx valid (< TwN)
   logic [2:0] draws_ff;   // draws remaining
   logic [1:0] chan_ff;
   logic      mono_ff;
   logic [2:0] pipe_ff;    // reads in flight
   logic [1:0] p0_ff, p1_ff; // channel tags through pipe
   logic      seed_ph_ff;  // seeding half step
   logic      rf_ph_ff;
   logic      out_valid_ff;
   logic [1:0] fin_ff;

   assign in_ready  = (state_ff == IDLE) && !out_valid_ff;
   assign out_valid = out_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.mono = mono_ff;
      cmd.idx = cnt_ff;
      unique case (state_ff)
         IDLE: begin
            if (in_valid && in_ready) begin
               cmd.load_pixel = 1'b1;
               if (in_frame_start) begin
                  cmd.seed_start = 1'b1;
                  cmd.idx = '0;
               end
            end
         end
         SEED: cmd.seed_step = seed_ph_ff;
         REFILL: begin
            cmd.refill_rd = !rf_ph_ff;
            cmd.refill_wr = rf_ph_ff;
         end
         DRAW: begin
            cmd.idx = tw_idx_ff;
            cmd.draw_rd = (draws_ff != 3'd0) && has_idx_ff;
            cmd.draw_use = pipe_ff[1];
            cmd.chan = p1_ff;
         end
         FINISH: begin
            cmd.draw_use = pipe_ff[1];
            cmd.chan = p1_ff;
            cmd.out_load = (fin_ff == 2'd2);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff <= '0;
         tw_idx_ff <= '0;
         has_idx_ff <= 1'b0;
         draws_ff <= '0;
         chan_ff <= '0;
         mono_ff <= 1'b1;
         pipe_ff <= '0;
         p0_ff <= '0;
         p1_ff <= '0;
         seed_ph_ff <= 1'b0;
         rf_ph_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         fin_ff <= '0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         pipe_ff <= {pipe_ff[1:0], cmd.draw_rd};
         p0_ff <= chan_ff;
         p1_ff <= p0_ff;
         unique case (state_ff)
            IDLE: begin
               if (in_valid && in_ready) begin
                  mono_ff <= !color_mode;
                  draws_ff <= color_mode ? 3'd4 : 3'd1;
                  chan_ff <= color_mode ? 2'd3 : 2'd0;
                  if (in_frame_start) begin
                     state_ff <= SEED;
                     cnt_ff <= idx_type'(1);
                     seed_ph_ff <= 1'b0;
                     has_idx_ff <= 1'b0;
                  end else if (!has_idx_ff) begin
                     state_ff <= REFILL;
                     cnt_ff <= '0;
                     rf_ph_ff <= 1'b0;
                  end else begin
                     state_ff <= DRAW;
                  end
               end
            end
            SEED: begin
               seed_ph_ff <= !seed_ph_ff;
               if (seed_ph_ff) begin
                  if (cnt_ff == idx_type'(TwN-1)) begin
                     state_ff <= REFILL;
                     cnt_ff <= '0;
                     rf_ph_ff <= 1'b0;
                  end else begin
                     cnt_ff <= cnt_ff + idx_type'(1);
                  end
               end
            end
            REFILL: begin
               rf_ph_ff <= !rf_ph_ff;
               if (rf_ph_ff) begin
                  if (cnt_ff == idx_type'(TwN-1)) begin
                     state_ff <= DRAW;
                     tw_idx_ff <= '0;
                     has_idx_ff <= 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff + idx_type'(1);
                  end
               end
            end
            DRAW: begin
               if (cmd.draw_rd) begin
                  draws_ff <= draws_ff - 3'd1;
                  chan_ff <= (chan_ff == 2'd3) ? 2'd0 : chan_ff + 2'd1;
                  if (tw_idx_ff == idx_type'(TwN-1)) has_idx_ff <= 1'b0;
                  else tw_idx_ff <= tw_idx_ff + idx_type'(1);
               end
               if (draws_ff == 3'd0) begin
                  state_ff <= FINISH;
                  fin_ff <= '0;
               end else if (!has_idx_ff) begin
                  // generator block used up mid-pixel: refill, then resume
                  if (pipe_ff == 3'd0) begin
                     state_ff <= REFILL;
                     cnt_ff <= '0;
                     rf_ph_ff <= 1'b0;
                  end
               end
            end
            FINISH: begin
               fin_ff <= fin_ff + 2'd1;
               if (fin_ff == 2'd2) begin
                  out_valid_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/uniform_noise_pixel_injector.sv =====
// channel | direction | fields
// req_    | in        | frame_start, red, green, blue
// rsp_    | out       | red, green, blue
// csr_    | in        | write enable, index, 32-bit data
// The result follows the request transfer in mono and colour mode through one
// word read per draw, then product, clamp and output stages;
// the next request is taken the cycle after the result transfer, so a pixel is
// not taken before the result of the last one has been transferred.
// A pixel with frame_start reseeds the block word by word through the seed
// multiplier and then refills the block; any draw that crosses the end of the
// block adds another refill.
// Reset is synchronous; the output register holds until the transfer.
module uniform_noise_pixel_injector (
   input  logic        clock,
   input  logic        reset,
   unpi_pixel_if.sink   req,
   unpi_pixel_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import unpi_pkg::*;

   logic [15:0] amount_ff;
   logic        color_ff;
   logic [31:0] seed_ff;
   unpi_cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff <= AmountReset;
         color_ff <= 1'b0;
         seed_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_AMOUNT: amount_ff <= csr_write_data[15:0];
            CSR_COLOR:  color_ff <= csr_write_data[0];
            CSR_SEED:   seed_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   unpi_controller u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_frame_start(req.frame_start), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .color_mode(color_ff), .cmd
   );

   unpi_datapath u_dp (
      .clock, .cmd, .amount(amount_ff), .seed(seed_ff),
      .red_in(req.red), .green_in(req.green), .blue_in(req.blue),
      .red_out(rsp.red), .green_out(rsp.green), .blue_out(rsp.blue)
   );

   assign rsp.frame_start = 1'b0;

endmodule

// ===== rtl/unpi_checker.sv =====
module unpi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_no_accept_while_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_accept_not_ready_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
   a_no_result_right_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind uniform_noise_pixel_injector unpi_checker u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);

// ===== tb/sv/noise_pixel_checker.sv =====
module noise_pixel_checker
   import unpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   unpi_pixel_if       req,
   unpi_pixel_if       rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
   } rgb_pixel_type;

   rgb_pixel_type expected_pixels[$];

   bit [31:0] mt_words[TwN];
   int unsigned mt_pos;
   bit [15:0] amount_q8;
   bit        colour_on;
   bit [31:0] seed_value;

   function automatic void mt_reseed(bit [31:0] s);
      bit [31:0] prev;
      mt_words[0] = s;
      for (int i = 1; i < TwN; i++) begin
         prev = mt_words[i-1];
         mt_words[i] = SeedMul * (prev ^ (prev >> 30)) + 32'(i);
      end
      mt_pos = TwN;
   endfunction

   function automatic void mt_regenerate();
      bit [31:0] y;
      bit [31:0] v;
      for (int i = 0; i < TwN; i++) begin
         y = (mt_words[i] & 32'h80000000) | (mt_words[(i+1) % TwN] & 32'h7fffffff);
         v = mt_words[(i+TwM) % TwN] ^ (y >> 1);
         if (y[0]) v = v ^ MatrixA;
         mt_words[i] = v;
      end
      mt_pos = 0;
   endfunction

   function automatic bit [31:0] mt_next();
      bit [31:0] y;
      if (mt_pos >= TwN) mt_regenerate();
      y = mt_words[mt_pos];
      mt_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // noise in units of 2^-31 levels
   function automatic longint noise_of(bit [31:0] w);
      longint m;
      m = longint'({8'd0, w[31:8]}) - 64'sh800000;
      return m * longint'({48'd0, amount_q8});
   endfunction

   function automatic bit [7:0] add_noise(bit [7:0] p, longint n);
      longint s;
      longint r;
      s = (longint'({56'd0, p}) <<< 31) + n;
      if (s <= 0) return 8'd0;
      r = s >>> 31;
      if (r > 255) r = 255;
      return 8'(r);
   endfunction

   function automatic rgb_pixel_type noisy_pixel(bit fs, bit [7:0] r, bit [7:0] g,
                                                 bit [7:0] b);
      longint n0;
      longint n1;
      longint n2;
      rgb_pixel_type px;
      if (fs) mt_reseed(seed_value);
      n0 = noise_of(mt_next());
      if (colour_on) begin
         n0 = noise_of(mt_next());
         n1 = noise_of(mt_next());
         n2 = noise_of(mt_next());
      end else begin
         n1 = n0;
         n2 = n0;
      end
      px.red   = add_noise(r, n0);
      px.green = add_noise(g, n1);
      px.blue  = add_noise(b, n2);
      return px;
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         expected_pixels.delete();
         mismatches <= 0;
         pending <= 0;
         amount_q8 = AmountReset;
         colour_on = 1'b0;
         seed_value = 32'd0;
         mt_pos = TwN;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("ERROR: unexpected pixel %0d/%0d/%0d", rsp.red, rsp.green,
                           rsp.blue);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (want.red !== rsp.red || want.green !== rsp.green ||
                   want.blue !== rsp.blue) begin
                  if (mismatches < 10)
                     $display("ERROR: pixel exp %0d/%0d/%0d got %0d/%0d/%0d", want.red,
                              want.green, want.blue, rsp.red, rsp.green, rsp.blue);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req.valid && req.ready)
            expected_pixels.push_back(noisy_pixel(req.frame_start, req.red, req.green,
                                                  req.blue));
         if (csr_write_enable) begin
            case (csr_index)
               CSR_AMOUNT: amount_q8 = csr_write_data[15:0];
               CSR_COLOR:  colour_on = csr_write_data[0];
               CSR_SEED:   seed_value = csr_write_data;
               default: ;
            endcase
         end
         pending <= expected_pixels.size();
      end
   end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import unpi_pkg::*;

   localparam int CycleLimit = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_AMOUNT;
   logic [31:0] csr_write_data = '0;
   int          mismatches;
   int          pending;
   int          cycles = 0;
   int          hold_request = 0;
   bit          eager_sink = 1'b0;
   int          pixels_sent = 0;
   int          frames_sent = 0;

   unpi_pixel_if req ();
   unpi_pixel_if rsp ();

   uniform_noise_pixel_injector dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   noise_pixel_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .mismatches(mismatches), .pending(pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end else if (hold == 0 && !eager_sink && $urandom_range(0, 199) == 0)
            hold = $urandom_range(15, 70);
         if (hold > 0) begin
            hold--;
            rsp.ready = 1'b0;
         end else
            rsp.ready = eager_sink || ($urandom_range(0, 4) != 0);
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after the transfer, or after a random gap if gaps is set
   task automatic send_pixel(bit fs, bit [7:0] r, bit [7:0] g, bit [7:0] b, bit gaps);
      int roll;
      int gap;
      req.valid = 1'b1;
      req.frame_start = fs;
      req.red = r;
      req.green = g;
      req.blue = b;
      do @(posedge clock); while (!req.ready);
      pixels_sent++;
      if (fs) frames_sent++;
      @(negedge clock);
      roll = $urandom_range(0, 99);
      gap = !gaps ? 0 : roll < 60 ? 0 : roll < 95 ? $urandom_range(1, 4)
                                                  : $urandom_range(20, 80);
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic run_phase(int count, bit gaps, bit stall_sink, bit drain_midway);
      bit [7:0] corner[4] = '{8'd0, 8'd255, 8'd1, 8'd254};
      for (int k = 0; k < count; k++) begin
         if (stall_sink && k == 20) hold_request = 400;
         if (drain_midway && k == count / 2) begin
            req.valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if (k == 0)
            send_pixel(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), gaps);
         else if (k <= 8)
            send_pixel(1'b0, corner[k % 4], corner[(k + 1) % 4], corner[(k / 2) % 4],
                       gaps);
         else
            send_pixel($urandom_range(0, 63) == 0, 8'($urandom), 8'($urandom),
                       8'($urandom), gaps);
      end
      req.valid = 1'b0;
      wait_drained();
   endtask

   initial begin
      req.valid = 1'b0;
      req.frame_start = 1'b0;
      req.red = '0;
      req.green = '0;
      req.blue = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings first: mono, default amount, seed zero
      run_phase(120, 1'b1, 1'b1, 1'b0);

      csr_write(CSR_AMOUNT, 32'd65280);
      csr_write(CSR_COLOR, 32'd1);
      csr_write(CSR_SEED, 32'hffffffff);
      run_phase(130, 1'b1, 1'b0, 1'b1);

      csr_write(CSR_AMOUNT, 32'd0);
      csr_write(CSR_SEED, 32'd1);
      eager_sink = 1'b1;
      run_phase(100, 1'b0, 1'b0, 1'b0);
      eager_sink = 1'b0;

      // amount above the nominal top, mono; index 3 must be ignored
      csr_write(CSR_AMOUNT, 32'hffffffff);
      csr_write(CSR_COLOR, 32'd0);
      csr_write(CSR_SEED, $urandom);
      csr_write(2'd3, $urandom);
      run_phase(130, 1'b1, 1'b0, 1'b0);

      for (int p = 0; p < 3; p++) begin
         csr_write(CSR_AMOUNT, $urandom_range(0, 65280));
         csr_write(CSR_COLOR, $urandom);
         csr_write(CSR_SEED, $urandom);
         run_phase(140, 1'b1, p == 1, p == 2);
      end

      $display("%0d pixels sent, %0d with frame start, over 7 register settings",
               pixels_sent, frames_sent);
      $display("mono and colour modes, amounts 0 to 65535, long sink stall, full drain");
      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
